FILE: rtl/core/bbd_pkg.sv
// Shared types and constants for the bucket-brigade delay tracker.
// No dependencies.
`default_nettype none
package bbd_pkg;
   localparam int BUCKET_LENGTH = 1024;
   localparam int IDX_W = $clog2(BUCKET_LENGTH);
   localparam int PERIOD_W = 23;
   localparam int TOTAL_W = 33;
   localparam int FRAC_W = 24;
   localparam int CLK_W = 6;
   localparam int LFO_W = 16;
   localparam int KNOB_W = 17;
   localparam int RATE_W = 18;
   localparam int CSR_W = 18;
   localparam int CSR_ADDR_W = 2;
   localparam int DIV_W = 62;
   localparam int NC_W = 47;
   localparam int PFS_W = PERIOD_W + RATE_W;
   localparam int Q_W = 43;
   localparam int ACC_W = Q_W + 1;
   localparam int X_W = 36;
   localparam int RECIP_SPLIT = 18;
   localparam int PROD_W = X_W + RECIP_SPLIT;
   localparam int SUM_W = PROD_W + RECIP_SPLIT;
   localparam int RECIP_SHIFT = 48;

   localparam logic [CSR_ADDR_W-1:0] CSR_MANUAL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEPTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATE   = 2'd2;

   localparam logic [KNOB_W-1:0] MANUAL_RESET = 17'd32768;
   localparam logic [KNOB_W-1:0] DEPTH_RESET  = 17'd32768;
   localparam logic [RATE_W-1:0] RATE_RESET   = 18'd48000;
   localparam logic [KNOB_W-1:0] KNOB_ONE     = 17'd65536;

   localparam logic signed [31:0] A_BASE   = 32'sd552468480;
   localparam logic signed [31:0] LFO_GAIN = 32'sd5000;
   localparam logic [14:0] M_GAIN = 15'd29445;
   localparam logic [NC_W-1:0] N_MAX = NC_W'(64'd29445 << 32);
   localparam logic [DIV_W-1:0] DEN_HALF = DIV_W'(64'd5889 << 23);
   localparam logic [DIV_W-1:0] RATE_NUM = DIV_W'(64'd4294967296000000000);
   // ceil(2^48 / 5889), split into two 18-bit halves
   localparam logic [RECIP_SPLIT-1:0] RECIP_HI = 18'd182330;
   localparam logic [RECIP_SPLIT-1:0] RECIP_LO = 18'd20210;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN = 23'd512000;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 23'd6400000;
   localparam logic [CLK_W-1:0] MAX_CLOCKS = 6'd63;

   typedef enum logic [3:0] {
      S_IDLE, S_LFO, S_MUL, S_SUM, S_SCALE, S_PLO, S_PHI, S_PSUM, S_PFS,
      S_QSTART, S_QWAIT, S_ACC, S_FILL, S_RD, S_WR, S_DONE
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/core/bbd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module bbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/bbd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bbd_pkg.
`default_nettype none
module bbd_div import bbd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic      [DIV_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bucket_brigade_delay_tracker.sv
// Bucket-brigade delay tracker top level: sequencer, ring memory, divider.
// Depends on bbd_pkg, bbd_ram and bbd_div.
//
// One request is worked at a time. An advance request passes from
// acceptance to a valid response through the bucket-period states (S_LFO to
// S_PFS, whose scaling uses a reciprocal multiply in S_PLO and S_PHI), then a
// 62-step division in the divider for the clocks per sample, then a read
// state and a write state per bucket clock for the read-modify-write on the
// ring memory. A clear request computes the period the same way, then sweeps
// all BUCKET_LENGTH entries of the ring, one write per cycle. A new request
// is taken while the previous response still waits in the output register.
`default_nettype none
module bucket_brigade_delay_tracker import bbd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // lfo_value[15:0]
   input  wire logic                  req_tuser,  // mode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [39:0]           rsp_tdata,  // delay_total[32:0], bucket_clocks[38:33], 0
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]      csr_wdata
);
   state_type state_ff, state_in;

   logic [KNOB_W-1:0]  manual_ff, depth_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic               mode_ff, mode_in;
   logic [LFO_W-1:0]   lfo_ff, lfo_in;
   logic [29:0]        a_ff, a_in;
   logic [31:0]        mm_ff, mm_in;
   logic [47:0]        da_ff, da_in;
   logic signed [50:0] dm_ff, dm_in;
   logic [NC_W-1:0]    nc_ff, nc_in;
   logic [DIV_W-1:0]   num_ff, num_in;
   logic [PROD_W-1:0]  plo_ff, plo_in, phi_ff, phi_in;
   logic [PERIOD_W-1:0] p_ff, p_in;
   logic [PFS_W-1:0]   pfs_ff, pfs_in;
   logic [IDX_W-1:0]   wp_ff, wp_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [CLK_W-1:0]   cnt_ff, cnt_in, left_ff, left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;

   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_dividend, div_divisor, div_quo;
   logic               ram_we;
   logic [PERIOD_W-1:0] ram_rdata;
   logic               rsp_load;
   logic signed [31:0] a_full;
   logic signed [17:0] dneg;
   logic signed [52:0] n_full;
   logic [X_W-1:0]     px;
   logic [SUM_W-1:0]   psum;
   logic [RATE_W-1:0]  fs_eff;
   logic [ACC_W-1:0]   acc;
   logic [IDX_W-1:0]   wp_next;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign wp_next    = (int'(wp_ff) == BUCKET_LENGTH - 1) ? '0 : wp_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_LFO;
         S_LFO:    state_in = S_MUL;
         S_MUL:    state_in = S_SUM;
         S_SUM:    state_in = S_SCALE;
         S_SCALE:  state_in = S_PLO;
         S_PLO:    state_in = S_PHI;
         S_PHI:    state_in = S_PSUM;
         S_PSUM:   state_in = S_PFS;
         S_PFS:    state_in = mode_ff ? S_FILL : S_QSTART;
         S_QSTART: state_in = S_QWAIT;
         S_QWAIT:  if (div_done) state_in = S_ACC;
         S_ACC:    state_in = (acc[ACC_W-1:FRAC_W] == '0) ? S_DONE : S_RD;
         S_FILL:   if (int'(wp_ff) == BUCKET_LENGTH - 1) state_in = S_DONE;
         S_RD:     state_in = S_WR;
         S_WR:     state_in = (left_ff == CLK_W'(1)) ? S_DONE : S_RD;
         S_DONE:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      lfo_in   = lfo_ff;
      a_in     = a_ff;
      mm_in    = mm_ff;
      da_in    = da_ff;
      dm_in    = dm_ff;
      nc_in    = nc_ff;
      num_in   = num_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      p_in     = p_ff;
      pfs_in   = pfs_ff;
      wp_in    = wp_ff;
      total_in = total_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      ram_we   = 1'b0;
      div_start = 1'b0;
      div_dividend = RATE_NUM;
      div_divisor  = DIV_W'(pfs_ff);
      a_full   = A_BASE + $signed(lfo_ff) * LFO_GAIN;
      dneg     = $signed({1'b0, KNOB_ONE}) - $signed({1'b0, depth_ff});
      n_full   = $signed({3'b0, da_ff, 1'b0}) + 53'(dm_ff);
      px       = num_ff[FRAC_W+X_W-1:FRAC_W];
      psum     = {phi_ff, {RECIP_SPLIT{1'b0}}} + SUM_W'(plo_ff);
      fs_eff   = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
      acc      = ACC_W'(div_quo[Q_W-1:0]) + ACC_W'(frac_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               lfo_in  = req_tuser ? '0 : req_tdata;
            end
         end
         S_LFO: begin
            a_in  = a_full[29:0];
            mm_in = 32'(manual_ff * M_GAIN);
         end
         S_MUL: begin
            da_in = 48'(depth_ff * a_ff);
            dm_in = 51'(dneg * $signed({1'b0, mm_ff}));
         end
         S_SUM: begin
            if (n_full < 0) begin
               nc_in = '0;
            end else if (n_full > $signed({6'b0, N_MAX})) begin
               nc_in = N_MAX;
            end else begin
               nc_in = n_full[NC_W-1:0];
            end
         end
         S_SCALE: begin
            num_in = DIV_W'({nc_ff, 12'b0}) + DIV_W'({nc_ff, 9'b0})
                     - DIV_W'({nc_ff, 3'b0}) + DEN_HALF;
         end
         S_PLO: plo_in = PROD_W'(px * RECIP_LO);
         S_PHI: phi_in = PROD_W'(px * RECIP_HI);
         S_PSUM: begin
            p_in = PERIOD_MIN + psum[RECIP_SHIFT+PERIOD_W-1:RECIP_SHIFT];
         end
         S_PFS: begin
            if (mode_ff) begin
               total_in = TOTAL_W'(64'(p_ff) * 64'(BUCKET_LENGTH));
               wp_in    = '0;
               frac_in  = '0;
               cnt_in   = '0;
            end else begin
               pfs_in = PFS_W'(p_ff * fs_eff);
            end
         end
         S_QSTART: div_start = 1'b1;
         S_ACC: begin
            frac_in = acc[FRAC_W-1:0];
            if (acc[ACC_W-1:FRAC_W] > ACC_W'(MAX_CLOCKS)) begin
               cnt_in = MAX_CLOCKS;
            end else begin
               cnt_in = acc[FRAC_W+CLK_W-1:FRAC_W];
            end
            left_in = cnt_in;
         end
         S_FILL: begin
            ram_we = 1'b1;
            wp_in  = wp_next;
         end
         S_WR: begin
            ram_we   = 1'b1;
            total_in = TOTAL_W'(total_ff + TOTAL_W'(p_ff) - TOTAL_W'(ram_rdata));
            wp_in    = wp_next;
            left_in  = left_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, cnt_ff, total_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         manual_ff    <= MANUAL_RESET;
         depth_ff     <= DEPTH_RESET;
         rate_ff      <= RATE_RESET;
         wp_ff        <= '0;
         total_ff     <= '0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         total_ff     <= total_in;
         frac_ff      <= frac_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_MANUAL: manual_ff <= csr_wdata[KNOB_W-1:0];
               CSR_DEPTH:  depth_ff  <= csr_wdata[KNOB_W-1:0];
               CSR_RATE:   rate_ff   <= csr_wdata[RATE_W-1:0];
               default: ;
            endcase
         end
      end
      mode_ff     <= mode_in;
      lfo_ff      <= lfo_in;
      a_ff        <= a_in;
      mm_ff       <= mm_in;
      da_ff       <= da_in;
      dm_ff       <= dm_in;
      nc_ff       <= nc_in;
      num_ff      <= num_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      p_ff        <= p_in;
      pfs_ff      <= pfs_in;
      cnt_ff      <= cnt_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bbd_ram #(
      .WIDTH (PERIOD_W),
      .DEPTH (BUCKET_LENGTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (p_ff),
      .raddr (wp_ff),
      .rdata (ram_rdata)
   );

   bbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      int'(wp_ff) < BUCKET_LENGTH)
      else $error("write pointer out of ring");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_QWAIT))
      else $error("divider finished outside a wait state");

   a_period_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PFS) |-> (p_ff >= PERIOD_MIN && p_ff <= PERIOD_MAX))
      else $error("bucket period out of range");

   a_clear_clocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && mode_ff) |-> (cnt_ff == '0 && frac_ff == '0))
      else $error("clear left clocks or fraction");
endmodule
`default_nettype wire
